[rtl/core/ctpm_pkg.sv]
// ---------------------------------------------------------------------------
// ctpm_pkg
// Shared types and constants of the coolant temperature plausibility monitor.
// ---------------------------------------------------------------------------
package ctpm_pkg;

  // register index codes of the configuration port
  localparam int CfgIdxWidth = 3;
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_MIN_SPEED_FOR_CUT = 3'd0,
    REG_CUT_DELAY_LOW     = 3'd1,
    REG_CUT_DELAY_HIGH    = 3'd2,
    REG_TRACKER_OFFSET    = 3'd3,
    REG_TRACKER_CEILING   = 3'd4,
    REG_WARMUP_HYSTERESIS = 3'd5,
    REG_WARMUP_TDC_LIMIT  = 3'd6
  } cfg_reg_t;

  localparam int CfgDataWidth = 16;

  // operation codes of an input item
  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  // register reset values
  localparam logic [7:0]  CutDelayHighReset   = 8'd255;
  localparam logic [7:0]  TrackerCeilingReset = 8'd254;

  // fixed limits
  localparam logic [7:0]  CounterMax   = 8'd255;
  localparam logic [7:0]  TrackerMax   = 8'd254;
  localparam logic signed [11:0] TempBias     = 12'sd40;
  localparam logic signed [11:0] WarmupOffset = 12'sd316;

  typedef struct packed {
    logic [7:0]  min_speed_for_cut;
    logic [7:0]  cut_delay_low;
    logic [7:0]  cut_delay_high;
    logic [7:0]  tracker_offset;
    logic [7:0]  tracker_ceiling;
    logic [7:0]  warmup_hysteresis;
    logic [15:0] warmup_tdc_limit;
  } cfg_t;

  typedef struct packed {
    op_t               operation;
    logic signed [8:0] coolant_temp;
    logic              injection_on;
    logic [7:0]        vehicle_speed;
    logic              diag_inhibit;
    logic              vehicle_running;
    logic [15:0]       tdc_count;
    logic [7:0]        stall_threshold;
  } item_t;

  typedef struct packed {
    logic [7:0] cut_count;
    logic       delay_flag;
    logic [7:0] tracker;
    logic       warmup_done;
    logic [7:0] stall_thd;
    logic       mon_tracker;
    logic       mon_warmup;
    logic       waiting;
    logic       fault_tracker;
    logic       fault_warmup;
  } state_t;

endpackage

[rtl/core/ctpm_cfg_regs.sv]
// ---------------------------------------------------------------------------
// ctpm_cfg_regs
// Configuration register file, written one register per beat.
// ---------------------------------------------------------------------------
module ctpm_cfg_regs
  import ctpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    wr_en,
  input  logic [CfgIdxWidth-1:0]  wr_index,
  input  logic [CfgDataWidth-1:0] wr_data,
  output cfg_t                    cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_speed_for_cut <= '0;
      cfg.cut_delay_low     <= '0;
      cfg.cut_delay_high    <= CutDelayHighReset;
      cfg.tracker_offset    <= '0;
      cfg.tracker_ceiling   <= TrackerCeilingReset;
      cfg.warmup_hysteresis <= '0;
      cfg.warmup_tdc_limit  <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_MIN_SPEED_FOR_CUT: cfg.min_speed_for_cut <= wr_data[7:0];
        REG_CUT_DELAY_LOW:     cfg.cut_delay_low     <= wr_data[7:0];
        REG_CUT_DELAY_HIGH:    cfg.cut_delay_high    <= wr_data[7:0];
        REG_TRACKER_OFFSET:    cfg.tracker_offset    <= wr_data[7:0];
        REG_TRACKER_CEILING:   cfg.tracker_ceiling   <= wr_data[7:0];
        REG_WARMUP_HYSTERESIS: cfg.warmup_hysteresis <= wr_data[7:0];
        REG_WARMUP_TDC_LIMIT:  cfg.warmup_tdc_limit  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/ctpm_step.sv]
// ---------------------------------------------------------------------------
// ctpm_step
// Next-state logic for one item: counter, hysteresis, tracker and flags.
// ---------------------------------------------------------------------------
module ctpm_step
  import ctpm_pkg::*;
(
  input  cfg_t   cfg,
  input  item_t  item,
  input  state_t cur,
  output state_t nxt
);

  logic signed [11:0] temp_x;
  logic [10:0]        thd5_new;
  logic [10:0]        thd5_old;
  logic [10:0]        rs_num;
  logic signed [11:0] rs_lim;
  logic signed [11:0] tk_raw;
  logic signed [11:0] tk_sum;
  logic signed [11:0] tk_lim;
  logic               cut_cond;
  logic [7:0]         cnt_new;
  logic               dly_new;
  logic signed [11:0] trk_d;
  logic signed [11:0] trk_cap;
  logic signed [11:0] trk_floor;
  logic signed [11:0] trk_d1;
  logic signed [11:0] trk_d2;
  logic signed [11:0] trk_d3;
  logic [7:0]         trk_new;
  logic               mon_trk;
  logic               mon_wup;
  logic               wait_new;
  logic               f_trk;
  logic               f_wup;

  // sign-extended temperature and stall threshold times five
  assign temp_x   = $signed({{3{item.coolant_temp[8]}}, item.coolant_temp});
  assign thd5_new = {1'b0, item.stall_threshold, 2'b00} + {3'b000, item.stall_threshold};
  assign thd5_old = {1'b0, cur.stall_thd, 2'b00} + {3'b000, cur.stall_thd};

  // restart limit, rounded division by eight of a nonnegative value
  assign rs_num = thd5_new + 11'd4;
  assign rs_lim = $signed({4'b0000, rs_num[10:3]})
                + $signed({4'b0000, cfg.warmup_hysteresis}) - TempBias;

  // tick limit, division by eight truncated toward zero
  assign tk_raw = $signed({1'b0, thd5_old}) - WarmupOffset;
  assign tk_sum = tk_raw[11] ? ((tk_raw + 12'sd7) >>> 3) : (tk_raw >>> 3);
  assign tk_lim = tk_sum + $signed({4'b0000, cfg.warmup_hysteresis});

  // saturating fuel cut counter
  assign cut_cond = !item.injection_on && (item.vehicle_speed >= cfg.min_speed_for_cut);
  always_comb begin
    cnt_new = cur.cut_count;
    if (cut_cond) begin
      if (cur.cut_count != CounterMax) cnt_new = cur.cut_count + 8'd1;
    end else begin
      if (cur.cut_count != 8'd0) cnt_new = cur.cut_count - 8'd1;
    end
  end

  // hysteresis flag, set test wins on overlapping limits
  always_comb begin
    dly_new = cur.delay_flag;
    if (cnt_new >= cfg.cut_delay_high) dly_new = 1'b1;
    else if (cnt_new <= cfg.cut_delay_low) dly_new = 1'b0;
  end

  // monotonic capped tracker
  assign trk_d     = temp_x - $signed({4'b0000, cfg.tracker_offset});
  assign trk_cap   = $signed({4'b0000, cfg.tracker_ceiling}) - TempBias;
  assign trk_floor = $signed({4'b0000, cur.tracker}) - TempBias;
  assign trk_d1    = (trk_d > trk_cap) ? trk_cap : trk_d;
  assign trk_d2    = (trk_d1 < trk_floor) ? trk_floor : trk_d1;
  assign trk_d3    = trk_d2 + TempBias;
  always_comb begin
    if (!cur.warmup_done) trk_new = cur.tracker;
    else if (trk_d3 > $signed({4'b0000, TrackerMax})) trk_new = TrackerMax;
    else if (trk_d3 < 12'sd0) trk_new = 8'd0;
    else trk_new = trk_d3[7:0];
  end

  // monitor flags from the warm-up state before this tick
  assign mon_trk = !item.diag_inhibit && item.vehicle_running && cur.warmup_done;
  assign mon_wup = !item.diag_inhibit && item.vehicle_running && !cur.warmup_done;

  assign f_trk = mon_trk && dly_new
              && (temp_x < ($signed({4'b0000, trk_new}) - TempBias));

  assign wait_new = mon_wup && (temp_x <= tk_lim)
                 && (item.tdc_count <= cfg.warmup_tdc_limit);

  // warm-up fault holds while still waiting
  always_comb begin
    if (!mon_wup) f_wup = 1'b0;
    else if (!wait_new) f_wup = dly_new && (temp_x < tk_sum);
    else f_wup = cur.fault_warmup;
  end

  // select restart or tick update
  always_comb begin
    nxt = cur;
    case (item.operation)
      OP_RESTART: begin
        nxt.cut_count   = '0;
        nxt.tracker     = '0;
        nxt.stall_thd   = item.stall_threshold;
        nxt.warmup_done = temp_x > rs_lim;
      end
      OP_TICK: begin
        nxt.cut_count     = cnt_new;
        nxt.delay_flag    = dly_new;
        nxt.tracker       = trk_new;
        nxt.mon_tracker   = mon_trk;
        nxt.mon_warmup    = mon_wup;
        nxt.waiting       = wait_new;
        nxt.warmup_done   = cur.warmup_done | (cur.waiting & !wait_new);
        nxt.fault_tracker = f_trk;
        nxt.fault_warmup  = f_wup;
      end
      default: ;
    endcase
  end

endmodule

[rtl/core/coolant_temp_plausibility_monitor.sv]
// ---------------------------------------------------------------------------
// coolant_temp_plausibility_monitor
// Fuel cut counter, temperature tracker and warm-up coherence flags.
// ---------------------------------------------------------------------------
//  channel   handshake                  payload
//  item      item_valid/item_stall      operation .. stall_threshold
//  result    result_valid/result_stall  cut_counter .. fault_warmup
//  config    cfg_valid/cfg_ready        cfg_index, cfg_data
//
// An item beat lands in the input register and is evaluated when the result
// is not stalled; its result goes to the state register, which is the output.
// One item per cycle while the result is not stalled; result_valid rises once
// the item has passed the input register and the state register.
// A stalled result holds the next item in the input register; item_stall
// rises only when that register is full and cannot drain.
// Synchronous reset clears the valid flags and state register; cfg_ready is always high.
// ---------------------------------------------------------------------------
module coolant_temp_plausibility_monitor
  import ctpm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // item channel
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic                    operation,
  input  logic signed [8:0]       coolant_temp,
  input  logic                    injection_on,
  input  logic [7:0]              vehicle_speed,
  input  logic                    diag_inhibit,
  input  logic                    vehicle_running,
  input  logic [15:0]             tdc_count,
  input  logic [7:0]              stall_threshold,
  // result channel
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [7:0]              cut_counter,
  output logic                    cut_delay_flag,
  output logic [7:0]              tracker_value,
  output logic                    warmup_done,
  output logic                    monitor_tracker,
  output logic                    monitor_warmup,
  output logic                    warmup_waiting,
  output logic                    fault_tracker,
  output logic                    fault_warmup,
  // configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data
);

  cfg_t   cfg;
  item_t  in_item;
  logic   in_valid;
  state_t state;
  state_t state_next;
  logic   item_fire;
  logic   proc;

  // configuration registers
  assign cfg_ready = 1'b1;

  ctpm_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake control
  assign proc       = in_valid && (!result_valid || !result_stall);
  assign item_stall = in_valid && !proc;
  assign item_fire  = item_valid && !item_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= item_fire || (in_valid && !proc);
    end
    if (item_fire) begin
      in_item.operation       <= op_t'(operation);
      in_item.coolant_temp    <= coolant_temp;
      in_item.injection_on    <= injection_on;
      in_item.vehicle_speed   <= vehicle_speed;
      in_item.diag_inhibit    <= diag_inhibit;
      in_item.vehicle_running <= vehicle_running;
      in_item.tdc_count       <= tdc_count;
      in_item.stall_threshold <= stall_threshold;
    end
  end

  // next-state evaluation
  ctpm_step u_step (
    .cfg  (cfg),
    .item (in_item),
    .cur  (state),
    .nxt  (state_next)
  );

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= proc || (result_valid && result_stall);
      if (proc) state <= state_next;
    end
  end

  assign cut_counter     = state.cut_count;
  assign cut_delay_flag  = state.delay_flag;
  assign tracker_value   = state.tracker;
  assign warmup_done     = state.warmup_done;
  assign monitor_tracker = state.mon_tracker;
  assign monitor_warmup  = state.mon_warmup;
  assign warmup_waiting  = state.waiting;
  assign fault_tracker   = state.fault_tracker;
  assign fault_warmup    = state.fault_warmup;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (in_valid && result_valid && result_stall))
    else $error("item stall without a held item");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !proc |=> $stable(state))
    else $error("state changed without an item");

  a_tracker_capped: assert property (@(posedge clk) disable iff (rst)
    tracker_value <= TrackerMax)
    else $error("tracker above its maximum");

  a_warmup_rise_cause: assert property (@(posedge clk) disable iff (rst)
    (proc && !state.warmup_done && state_next.warmup_done
     && in_item.operation == OP_TICK) |-> state.waiting)
    else $error("warm-up completed without a falling wait");

endmodule
